### sv/madc_pkg.sv
// Package for the multidimensional array address calculator.
// Holds command codes, default sizes and the controller/datapath interface types.
// No dependencies.
package madc_pkg;

   localparam int MAX_DIMS_DEF   = 10;
   localparam int NUM_ARRAYS_DEF = 16;

   localparam logic [1:0] CMD_HEADER = 2'd0;
   localparam logic [1:0] CMD_BOUNDS = 2'd1;
   localparam logic [1:0] CMD_INDEX  = 2'd2;

   typedef struct packed {
      logic take;
      logic mac;
      logic fin;
   } ctrl_cmd_type;

   typedef struct packed {
      logic start;
      logic last;
   } ctrl_status_type;

endpackage

### sv/madc_dpath.sv
// Datapath: descriptor tables, bounds memories, offset accumulator and result register.
// Depends on madc_pkg; driven by madc_ctrl through ctrl_cmd_type.
module madc_dpath
   import madc_pkg::*;
#(
   parameter int MAX_DIMS   = MAX_DIMS_DEF,
   parameter int NUM_ARRAYS = NUM_ARRAYS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        cmd,
   output ctrl_status_type     status,
   input  logic [1:0]          req_cmd,
   input  logic [3:0]          req_array_id,
   input  logic [3:0]          req_dim_sel,
   input  logic signed [31:0]  req_base_addr,
   input  logic [15:0]         req_element_bytes,
   input  logic [3:0]          req_dim_count,
   input  logic signed [15:0]  req_low_bound,
   input  logic signed [15:0]  req_high_bound,
   input  logic signed [15:0]  req_index_value,
   output logic signed [31:0]  rsp_element_addr,
   output logic [3:0]          rsp_ref_array
);

   localparam int AW    = (NUM_ARRAYS > 1) ? $clog2(NUM_ARRAYS) : 1;
   localparam int DW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int NW    = $clog2(MAX_DIMS + 1);
   localparam int SLOTS = NUM_ARRAYS * MAX_DIMS;
   localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic [31:0]   base_mem [NUM_ARRAYS];
   logic [15:0]   elem_mem [NUM_ARRAYS];
   logic [NW-1:0] ndims_mem [NUM_ARRAYS];
   logic [15:0]   low_mem [SLOTS];
   logic [15:0]   high_mem [SLOTS];

   logic [DW-1:0] dims_seen_ff, dims_seen_in;
   logic [AW-1:0] cur_arr_ff, cur_arr_in;
   logic [31:0]   acc_ff, acc_in;
   logic [15:0]   idx_ff;
   logic [31:0]   base_rd_ff;
   logic [15:0]   elem_rd_ff;
   logic [NW-1:0] ndims_rd_ff;
   logic [15:0]   low_rd_ff, high_rd_ff;
   logic [31:0]   addr_ff;
   logic [3:0]    arr_out_ff;

   logic [31:0]   id_ext, dsel_ext, n_ext, n_clamp;
   logic          id_ok, dsel_ok, first;
   logic [AW-1:0] id_arr, arr_sel;
   logic [31:0]   slot_rd_full, slot_wr_full;
   logic [SW-1:0] slot_rd, slot_wr;
   logic [DW:0]   seen_next;
   logic [31:0]   diff, ext, mac_prod, scale, addr_in;

   assign id_ext   = {28'd0, req_array_id};
   assign dsel_ext = {28'd0, req_dim_sel};
   assign n_ext    = {28'd0, req_dim_count};
   assign id_ok    = id_ext < 32'(NUM_ARRAYS);
   assign dsel_ok  = dsel_ext < 32'(MAX_DIMS);
   assign id_arr   = id_ext[AW-1:0];
   assign first    = (dims_seen_ff == '0);
   assign arr_sel  = first ? id_arr : cur_arr_ff;

   assign n_clamp = (n_ext == 32'd0) ? 32'd1 :
                    (n_ext > 32'(MAX_DIMS)) ? 32'(MAX_DIMS) : n_ext;

   assign slot_rd_full = 32'(arr_sel) * 32'(MAX_DIMS) + 32'(dims_seen_ff);
   assign slot_wr_full = 32'(id_arr) * 32'(MAX_DIMS) + dsel_ext;
   assign slot_rd      = slot_rd_full[SW-1:0];
   assign slot_wr      = slot_wr_full[SW-1:0];

   // header tables
   always_ff @(posedge clock) begin
      if (cmd.take && req_cmd == CMD_HEADER && id_ok) begin
         base_mem[id_arr]  <= req_base_addr;
         elem_mem[id_arr]  <= req_element_bytes;
         ndims_mem[id_arr] <= n_clamp[NW-1:0];
      end
      if (cmd.take) begin
         base_rd_ff  <= base_mem[arr_sel];
         elem_rd_ff  <= elem_mem[arr_sel];
         ndims_rd_ff <= ndims_mem[arr_sel];
      end
   end

   // bounds memories
   always_ff @(posedge clock) begin
      if (cmd.take && req_cmd == CMD_BOUNDS && id_ok && dsel_ok) begin
         low_mem[slot_wr]  <= req_low_bound;
         high_mem[slot_wr] <= req_high_bound;
      end
      if (cmd.take) begin
         low_rd_ff  <= low_mem[slot_rd];
         high_rd_ff <= high_mem[slot_rd];
         idx_ff     <= req_index_value;
      end
   end

   assign status.start = (req_cmd == CMD_INDEX) && (!first || id_ok);

   assign seen_next   = {1'b0, dims_seen_ff} + 1'b1;
   assign status.last = (32'(seen_next) >= 32'(ndims_rd_ff)) ||
                        (32'(seen_next) >= 32'(MAX_DIMS));

   assign diff     = {{16{idx_ff[15]}}, idx_ff} - {{16{low_rd_ff[15]}}, low_rd_ff};
   assign ext      = {{16{high_rd_ff[15]}}, high_rd_ff}
                     - {{16{low_rd_ff[15]}}, low_rd_ff} + 32'd1;
   assign mac_prod = acc_ff * ext;
   assign acc_in   = first ? diff : mac_prod + diff;

   assign scale   = {16'd0, elem_rd_ff} * acc_ff;
   assign addr_in = base_rd_ff + scale;

   always_comb begin
      dims_seen_in = dims_seen_ff;
      cur_arr_in   = cur_arr_ff;
      if (cmd.take && status.start && first) begin
         cur_arr_in = id_arr;
      end
      if (cmd.mac) begin
         dims_seen_in = status.last ? '0 : seen_next[DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_seen_ff <= '0;
         cur_arr_ff   <= '0;
      end else begin
         dims_seen_ff <= dims_seen_in;
         cur_arr_ff   <= cur_arr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mac) begin
         acc_ff <= acc_in;
      end
      if (cmd.fin) begin
         addr_ff    <= addr_in;
         arr_out_ff <= 4'(cur_arr_ff);
      end
   end

   assign rsp_element_addr = addr_ff;
   assign rsp_ref_array    = arr_out_ff;

endmodule

### sv/madc_ctrl.sv
// Controller: sequences accept, multiply-accumulate and final address steps.
// Depends on madc_pkg; commands madc_dpath and owns the result valid flag.
module madc_ctrl
   import madc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  ctrl_status_type  status,
   output ctrl_cmd_type     cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MAC  = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.take = req_valid;
            if (req_valid && status.start) begin
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            cmd.mac  = 1'b1;
            state_in = status.last ? ST_FIN : ST_IDLE;
         end
         ST_FIN: begin
            if (out_free) begin
               cmd.fin  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.fin) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

### sv/multidim_array_address_calc_unit.sv
// Row-major array address calculator. Header and bounds words never hold the input.
// An index word steps through a bounds memory read, then a multiply-accumulate;
// the last index of a reference adds a scale-and-base step, and rsp_valid rises
// when that step is registered, or later while the output is stalled.
// Synchronous reset clears the sequencer and reference progress; tables are not cleared.
module multidim_array_address_calc_unit
   import madc_pkg::*;
#(
   parameter int MAX_DIMS   = MAX_DIMS_DEF,
   parameter int NUM_ARRAYS = NUM_ARRAYS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic [3:0]         req_array_id,
   input  logic [3:0]         req_dim_sel,
   input  logic signed [31:0] req_base_addr,
   input  logic [15:0]        req_element_bytes,
   input  logic [3:0]         req_dim_count,
   input  logic signed [15:0] req_low_bound,
   input  logic signed [15:0] req_high_bound,
   input  logic signed [15:0] req_index_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_element_addr,
   output logic [3:0]         rsp_ref_array
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   madc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   madc_dpath #(
      .MAX_DIMS   (MAX_DIMS),
      .NUM_ARRAYS (NUM_ARRAYS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_cmd           (req_cmd),
      .req_array_id      (req_array_id),
      .req_dim_sel       (req_dim_sel),
      .req_base_addr     (req_base_addr),
      .req_element_bytes (req_element_bytes),
      .req_dim_count     (req_dim_count),
      .req_low_bound     (req_low_bound),
      .req_high_bound    (req_high_bound),
      .req_index_value   (req_index_value),
      .rsp_element_addr  (rsp_element_addr),
      .rsp_ref_array     (rsp_ref_array)
   );

endmodule

### sv/madc_checker.sv
// Port-level checker for the array address calculator, bound to the top level.
// Depends on madc_pkg for command codes.
module madc_checker
   import madc_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic [1:0]         req_cmd,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_element_addr
);

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("outputs not quiet after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_element_addr))
      else $error("stalled result word changed");

   a_table_write_single: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_cmd != CMD_INDEX |=> !req_stall)
      else $error("non-index word held the input side");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result word without preceding computation");

endmodule

bind multidim_array_address_calc_unit madc_checker u_madc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_cmd          (req_cmd),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_element_addr (rsp_element_addr)
);

### tb/sv/multidim_array_address_calc_unit_tb.sv
// Testbench for multidim_array_address_calc_unit: sends header, bounds and index words
// with random idle and output stall, predicts each element address and checks every result.
// Depends on madc_pkg and the multidim_array_address_calc_unit RTL.
module multidim_array_address_calc_unit_tb;
   import madc_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int NUM_SLOTS      = NUM_ARRAYS_DEF * MAX_DIMS_DEF;
   localparam int STALL_LIMIT    = 2000;
   localparam int RX_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES   = 8;

   typedef struct {
      logic [1:0]  cmd;
      logic [3:0]  array_id;
      logic [3:0]  dim_sel;
      logic [31:0] base_addr;
      logic [15:0] element_bytes;
      logic [3:0]  dim_count;
      logic [15:0] low_bound;
      logic [15:0] high_bound;
      logic [15:0] index_value;
   } desc_word_type;

   typedef struct {
      logic [31:0] addr;
      logic [3:0]  arr;
   } elem_ref_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_cmd;
   logic [3:0]         req_array_id;
   logic [3:0]         req_dim_sel;
   logic signed [31:0] req_base_addr;
   logic [15:0]        req_element_bytes;
   logic [3:0]         req_dim_count;
   logic signed [15:0] req_low_bound;
   logic signed [15:0] req_high_bound;
   logic signed [15:0] req_index_value;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_element_addr;
   logic [3:0]         rsp_ref_array;

   // descriptor tables as the block should hold them
   logic [31:0] base_mem  [NUM_ARRAYS_DEF];
   logic [15:0] esize_mem [NUM_ARRAYS_DEF];
   logic [3:0]  ndim_mem  [NUM_ARRAYS_DEF];
   logic [15:0] lo_mem    [NUM_SLOTS];
   logic [15:0] hi_mem    [NUM_SLOTS];
   bit          hdr_written [NUM_ARRAYS_DEF];
   bit          bnd_written [NUM_SLOTS];
   logic [31:0] run_offset = '0;
   int unsigned idx_count  = 0;
   logic [3:0]  ref_id     = '0;

   elem_ref_type pending_addrs [$];
   int        fail_count  = 0;
   int        words_sent  = 0;
   int        idle_cycles = 0;
   bit        tx_steady   = 1'b0;
   bit        rx_steady   = 1'b0;
   bit        hold_toggle = 1'b0;
   bit        hold_seen   = 1'b0;
   int        hold_left   = 0;

   multidim_array_address_calc_unit i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_array_id      (req_array_id),
      .req_dim_sel       (req_dim_sel),
      .req_base_addr     (req_base_addr),
      .req_element_bytes (req_element_bytes),
      .req_dim_count     (req_dim_count),
      .req_low_bound     (req_low_bound),
      .req_high_bound    (req_high_bound),
      .req_index_value   (req_index_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_element_addr  (rsp_element_addr),
      .rsp_ref_array     (rsp_ref_array)
   );

   always #2 clock = ~clock;

   function automatic logic [31:0] sext16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      fail_count++;
   endtask

   task automatic track_descriptor_word(input desc_word_type w);
      logic [3:0]  n;
      logic [31:0] idx;
      logic [31:0] lo;
      logic [31:0] ext;
      elem_ref_type done;
      int          slot;
      case (w.cmd)
         CMD_HEADER: begin
            n = (w.dim_count == 4'd0) ? 4'd1 : w.dim_count;
            if (n > MAX_DIMS_DEF) n = 4'(MAX_DIMS_DEF);
            base_mem[w.array_id]    = w.base_addr;
            esize_mem[w.array_id]   = w.element_bytes;
            ndim_mem[w.array_id]    = n;
            hdr_written[w.array_id] = 1'b1;
         end
         CMD_BOUNDS: begin
            if (w.dim_sel < MAX_DIMS_DEF) begin
               slot = w.array_id * MAX_DIMS_DEF + w.dim_sel;
               lo_mem[slot]      = w.low_bound;
               hi_mem[slot]      = w.high_bound;
               bnd_written[slot] = 1'b1;
            end
         end
         CMD_INDEX: begin
            idx = sext16(w.index_value);
            if (idx_count == 0) ref_id = w.array_id;
            slot = ref_id * MAX_DIMS_DEF + idx_count;
            lo   = sext16(lo_mem[slot]);
            ext  = sext16(hi_mem[slot]) - lo + 32'd1;
            if (idx_count == 0) run_offset = idx - lo;
            else run_offset = run_offset * ext + (idx - lo);
            idx_count++;
            if (idx_count >= ndim_mem[ref_id] || idx_count >= MAX_DIMS_DEF) begin
               done.addr = base_mem[ref_id] + {16'h0, esize_mem[ref_id]} * run_offset;
               done.arr  = ref_id;
               pending_addrs.push_back(done);
               idx_count  = 0;
               run_offset = '0;
            end
         end
         default: ;
      endcase
   endtask

   function automatic desc_word_type random_word();
      desc_word_type w;
      w.cmd           = 2'($urandom_range(0, 3));
      w.array_id      = 4'($urandom);
      w.dim_sel       = 4'($urandom);
      w.base_addr     = $urandom;
      w.element_bytes = 16'($urandom);
      w.dim_count     = 4'($urandom);
      w.low_bound     = 16'($urandom);
      w.high_bound    = 16'($urandom);
      w.index_value   = 16'($urandom);
      return w;
   endfunction

   task automatic send_word(input desc_word_type w);
      int gap;
      gap = (!tx_steady && $urandom_range(0, 99) < 15) ? $urandom_range(1, 3) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid         <= 1'b1;
      req_cmd           <= w.cmd;
      req_array_id      <= w.array_id;
      req_dim_sel       <= w.dim_sel;
      req_base_addr     <= w.base_addr;
      req_element_bytes <= w.element_bytes;
      req_dim_count     <= w.dim_count;
      req_low_bound     <= w.low_bound;
      req_high_bound    <= w.high_bound;
      req_index_value   <= w.index_value;
      do @(posedge clock); while (req_stall);
      words_sent++;
      track_descriptor_word(w);
   endtask

   task automatic send_header(input logic [3:0] id, input logic [31:0] base,
                              input logic [15:0] esize, input logic [3:0] dims);
      desc_word_type w;
      w               = random_word();
      w.cmd           = CMD_HEADER;
      w.array_id      = id;
      w.base_addr     = base;
      w.element_bytes = esize;
      w.dim_count     = dims;
      send_word(w);
   endtask

   task automatic send_bounds(input logic [3:0] id, input logic [3:0] dsel,
                              input logic [15:0] lo, input logic [15:0] hi);
      desc_word_type w;
      w            = random_word();
      w.cmd        = CMD_BOUNDS;
      w.array_id   = id;
      w.dim_sel    = dsel;
      w.low_bound  = lo;
      w.high_bound = hi;
      send_word(w);
   endtask

   task automatic send_index(input logic [3:0] id, input logic [15:0] value);
      desc_word_type w;
      w             = random_word();
      w.cmd         = CMD_INDEX;
      w.array_id    = id;
      w.index_value = value;
      send_word(w);
   endtask

   task automatic send_random_bounds(input logic [3:0] id, input logic [3:0] dsel);
      int lo;
      if ($urandom_range(0, 99) < 80) begin
         lo = int'($urandom_range(0, 40)) - 20;
         send_bounds(id, dsel, 16'(lo), 16'(lo + int'($urandom_range(0, 15))));
      end else begin
         send_bounds(id, dsel, 16'($urandom), 16'($urandom));
      end
   endtask

   // write whatever the next index would read before sending it
   task automatic send_legal_index(input logic [3:0] id);
      logic [3:0]  arr;
      logic [15:0] v;
      int          slot;
      int          lo_i;
      int          hi_i;
      arr = (idx_count == 0) ? id : ref_id;
      if (!hdr_written[arr])
         send_header(arr, $urandom, 16'($urandom), 4'($urandom_range(1, 3)));
      slot = arr * MAX_DIMS_DEF + idx_count;
      if (!bnd_written[slot]) send_random_bounds(arr, 4'(idx_count));
      lo_i = $signed(lo_mem[slot]);
      hi_i = $signed(hi_mem[slot]);
      if (hi_i >= lo_i && $urandom_range(0, 99) < 80)
         v = 16'(lo_i + int'($urandom_range(0, hi_i - lo_i)));
      else v = 16'($urandom);
      send_index(id, v);
   endtask

   task automatic run_reference(input logic [3:0] id);
      int n;
      if (!hdr_written[id] || $urandom_range(0, 99) < 20)
         send_header(id, $urandom, 16'($urandom),
                     4'(($urandom_range(0, 99) < 85) ? $urandom_range(1, 4)
                                                      : $urandom_range(0, 15)));
      n = ndim_mem[id];
      for (int d = 0; d < n; d++)
         if (!bnd_written[id * MAX_DIMS_DEF + d] || $urandom_range(0, 99) < 15)
            send_random_bounds(id, 4'(d));
      for (int d = 0; d < n; d++)
         send_legal_index(id);
   endtask

   task automatic test_extremes();
      send_header(4'd0, 32'h7FFF_FFFF, 16'hFFFF, 4'd0);
      send_bounds(4'd0, 4'd0, 16'h8000, 16'h7FFF);
      send_index(4'd0, 16'h7FFF);
      send_index(4'd0, 16'h8000);
      send_header(4'd15, 32'h8000_0000, 16'h0000, 4'd15);
   endtask

   task automatic test_ignored_words();
      desc_word_type w;
      w     = random_word();
      w.cmd = CMD_UNUSED;
      send_word(w);
      send_bounds(4'd0, 4'd15, 16'h0000, 16'h0000);
      send_bounds(4'd0, 4'd10, 16'h0001, 16'h0001);
      send_index(4'd0, 16'h0000);
   endtask

   task automatic test_mid_reference();
      send_header(4'd1, 32'h8000_0000, 16'd4, 4'd2);
      send_bounds(4'd1, 4'd0, 16'hFFFF, 16'h0001);
      send_bounds(4'd1, 4'd1, 16'h0000, 16'h0009);
      send_index(4'd1, 16'h0001);
      // continue array 1 despite the other id
      send_index(4'd7, 16'h0003);
      send_index(4'd1, 16'h0000);
      send_bounds(4'd1, 4'd1, 16'h0002, 16'h0005);
      // shrink the dimension count under a running reference
      send_header(4'd1, 32'h0000_1000, 16'd8, 4'd1);
      send_index(4'd1, 16'h0004);
   endtask

   task automatic test_random_mix(input int target);
      desc_word_type w;
      while (words_sent < target) begin
         if ($urandom_range(0, 99) < 70) begin
            run_reference(4'($urandom));
         end else begin
            w = random_word();
            if (w.cmd == CMD_INDEX) send_legal_index(w.array_id);
            else send_word(w);
         end
      end
   endtask

   task automatic test_back_to_back(input int refs);
      tx_steady = 1'b1;
      rx_steady = 1'b1;
      repeat (refs) run_reference(4'($urandom));
      tx_steady = 1'b0;
      rx_steady = 1'b0;
   endtask

   task automatic test_output_backpressure();
      send_header(4'd5, $urandom, 16'($urandom), 4'd1);
      send_bounds(4'd5, 4'd0, -16'sd100, 16'sd100);
      tx_steady   = 1'b1;
      hold_toggle = ~hold_toggle;
      repeat (40) send_legal_index(4'd5);
      tx_steady = 1'b0;
   endtask

   always @(negedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen = hold_toggle;
         hold_left = RX_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !rx_steady && ($urandom_range(0, 99) < 15);
      end
   end

   always @(posedge clock) begin : check_results
      elem_ref_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_addrs.size() == 0) begin
            report_mismatch($sformatf("unexpected result addr %08h array %0d",
                                      rsp_element_addr, rsp_ref_array));
         end else begin
            want = pending_addrs.pop_front();
            if (rsp_element_addr !== want.addr)
               report_mismatch($sformatf("element_addr %08h, expected %08h",
                                         rsp_element_addr, want.addr));
            if (rsp_ref_array !== want.arr)
               report_mismatch($sformatf("ref_array %0d, expected %0d",
                                         rsp_ref_array, want.arr));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_cmd           = CMD_HEADER;
      req_array_id      = '0;
      req_dim_sel       = '0;
      req_base_addr     = '0;
      req_element_bytes = '0;
      req_dim_count     = '0;
      req_low_bound     = '0;
      req_high_bound    = '0;
      req_index_value   = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_extremes();
      test_ignored_words();
      test_mid_reference();
      test_random_mix(650);
      test_back_to_back(30);
      test_output_backpressure();

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_addrs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule
